/* hw/rtl/substring_first_match_finder_core_assert.svh */
// Assertion macros used by the checker of the substring finder.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef SUBSTRING_FIRST_MATCH_FINDER_CORE_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFMF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("substring finder check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("substring finder check failed");

`endif

/* hw/rtl/sfmf_pkg.sv */
package sfmf_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int POS_W       = 16;
    localparam int START_W     = 16;
    localparam int LEN_W       = 4;
    localparam int SEEN_W      = $clog2(MAX_PATTERN + 1);
    localparam int CALC_W      = (POS_W > START_W) ? POS_W : START_W;

    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 5;
    localparam int IDX_LSB     = 3;

    typedef enum logic [ADDR_W-IDX_LSB-1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_IGNORE_CASE    = 2'd2
    } reg_index_t;

    // Maps ASCII upper case to lower case when folding is enabled.
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
        logic [7:0] r;
        r = b;
        if (fold_en && (b >= 8'h41) && (b <= 8'h5A))
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/substring_first_match_finder_core.sv */
// Streaming first-match substring finder. One text item (a byte plus an end-of-text
// flag) is accepted every clock cycle unless a stalled result holds off the input;
// each item goes through an input register and the window compare into a result
// register. A text gives at most one result: found with the start index when the
// pattern first completes, or not found on the final byte. A stalled result stalls
// the input only once the input register also holds a byte that produces a result.
// The pattern (up to eight bytes, first byte lowest), its length and the case
// folding switch are written over the APB port at byte addresses 0, 8 and 16; the
// user must do so only while no text is in flight; the block does not enforce it.
module substring_first_match_finder_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sfmf_pkg::ADDR_W-1:0]           paddr,
    input  logic [sfmf_pkg::DATA_W-1:0]           pwdata,
    output logic [sfmf_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  text_valid,
    output logic                                  text_ready,
    input  logic [7:0]                            text_byte,
    input  logic                                  last_byte,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic                                  found,
    output logic [sfmf_pkg::START_W-1:0]          match_start
);

    localparam int MaxPat = sfmf_pkg::MAX_PATTERN;

    // Configuration registers.
    logic [63:0]                  pattern_bytes_reg;
    logic [sfmf_pkg::LEN_W-1:0]   pattern_length_reg;
    logic                         ignore_case_reg;

    sfmf_pkg::reg_index_t         cfg_index;
    logic                         cfg_write;

    // Input register.
    logic                         s1_valid_reg;
    logic [7:0]                   s1_byte_reg;
    logic                         s1_last_reg;

    // Per-text search state.
    logic [7:0]                   window_reg [MaxPat];
    logic [sfmf_pkg::SEEN_W-1:0]  seen_reg;
    logic [sfmf_pkg::POS_W-1:0]   pos_reg;
    logic                         already_found_reg;

    // Result register.
    logic                         result_valid_reg;
    logic                         result_found_reg;
    logic [sfmf_pkg::START_W-1:0] result_start_reg;

    logic [7:0]                   win_shift [MaxPat];
    logic [7:0]                   win_fold  [MaxPat];
    logic [7:0]                   pat_fold  [MaxPat];
    logic [MaxPat-1:0]            len_match;
    logic                         sel_match;
    logic [sfmf_pkg::LEN_W-1:0]   eff_len;
    logic [sfmf_pkg::SEEN_W-1:0]  seen_next;
    logic [sfmf_pkg::POS_W-1:0]   pos_next;
    logic [sfmf_pkg::CALC_W-1:0]  start_calc;
    logic                         hit;
    logic                         produce;
    logic                         s1_advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = sfmf_pkg::reg_index_t'(paddr[sfmf_pkg::ADDR_W-1:sfmf_pkg::IDX_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
            ignore_case_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sfmf_pkg::REG_PATTERN_BYTES:  pattern_bytes_reg  <= pwdata[63:0];
                sfmf_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[sfmf_pkg::LEN_W-1:0];
                sfmf_pkg::REG_IGNORE_CASE:    ignore_case_reg    <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            sfmf_pkg::REG_PATTERN_BYTES:  prdata = sfmf_pkg::DATA_W'(pattern_bytes_reg);
            sfmf_pkg::REG_PATTERN_LENGTH: prdata = sfmf_pkg::DATA_W'(pattern_length_reg);
            sfmf_pkg::REG_IGNORE_CASE:    prdata = sfmf_pkg::DATA_W'(ignore_case_reg);
            default:                      prdata = '0;
        endcase
    end

    // Window compare for the byte held in the input register.
    always_comb
    begin
        win_shift[0] = s1_byte_reg;
        for (int k = 1; k < MaxPat; k++)
        begin
            win_shift[k] = window_reg[k-1];
        end
        for (int k = 0; k < MaxPat; k++)
        begin
            win_fold[k] = sfmf_pkg::fold_byte(win_shift[k], ignore_case_reg);
            pat_fold[k] = sfmf_pkg::fold_byte(pattern_bytes_reg[8*k +: 8], ignore_case_reg);
        end
        // Entry l-1 tells whether a pattern of length l ends at the newest byte.
        for (int l = 1; l <= MaxPat; l++)
        begin
            len_match[l-1] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (win_fold[k] != pat_fold[l-1-k])
                begin
                    len_match[l-1] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (pattern_length_reg > sfmf_pkg::LEN_W'(MaxPat))
        begin
            eff_len = sfmf_pkg::LEN_W'(MaxPat);
        end
        else
        begin
            eff_len = pattern_length_reg;
        end
        sel_match = 1'b0;
        for (int l = 1; l <= MaxPat; l++)
        begin
            if (eff_len == sfmf_pkg::LEN_W'(l))
            begin
                sel_match = len_match[l-1];
            end
        end
    end

    assign seen_next = (seen_reg < sfmf_pkg::SEEN_W'(MaxPat)) ? seen_reg + 1'b1 : seen_reg;
    assign pos_next  = (pos_reg != '1) ? pos_reg + 1'b1 : pos_reg;

    assign hit = !already_found_reg && (eff_len != '0)
                 && (sfmf_pkg::LEN_W'(seen_next) >= eff_len) && sel_match;

    assign start_calc = sfmf_pkg::CALC_W'(pos_reg)
                        - sfmf_pkg::CALC_W'(eff_len - sfmf_pkg::LEN_W'(1));

    assign produce    = hit || (s1_last_reg && !already_found_reg);
    assign s1_advance = s1_valid_reg && (!produce || !result_valid_reg || result_ready);
    assign text_ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (text_ready)
        begin
            s1_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            s1_byte_reg <= text_byte;
            s1_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MaxPat; k++)
            begin
                window_reg[k] <= '0;
            end
            seen_reg          <= '0;
            pos_reg           <= '0;
            already_found_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                // The final byte closes the text; the next item starts a new one.
                for (int k = 0; k < MaxPat; k++)
                begin
                    window_reg[k] <= '0;
                end
                seen_reg          <= '0;
                pos_reg           <= '0;
                already_found_reg <= 1'b0;
            end
            else
            begin
                for (int k = 0; k < MaxPat; k++)
                begin
                    window_reg[k] <= win_shift[k];
                end
                seen_reg          <= seen_next;
                pos_reg           <= pos_next;
                already_found_reg <= already_found_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_advance && produce)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && produce)
        begin
            result_found_reg <= hit;
            result_start_reg <= hit ? start_calc[sfmf_pkg::START_W-1:0] : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = result_found_reg;
    assign match_start  = result_start_reg;

endmodule

/* hw/rtl/sfmf_checker.sv */
`include "substring_first_match_finder_core_assert.svh"

module sfmf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         text_valid,
    input logic                         text_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic                         found,
    input logic [sfmf_pkg::START_W-1:0] match_start
);

    logic text_accept;
    logic result_stall;

    assign text_accept  = text_valid && text_ready;
    assign result_stall = result_valid && !result_ready;

    // A stalled result keeps its value.
    `SFMF_ASSERT_NEXT(a_result_hold, result_stall, result_valid && $stable({found, match_start}))

    // A not-found result carries a zero start index.
    `SFMF_ASSERT_SAME(a_not_found_zero, result_valid && !found, match_start == '0)

    // A fresh result always traces back to an accepted item that passed the input register.
    `SFMF_ASSERT_SAME(a_result_latency, $rose(result_valid), $past($past(text_accept)))

    // With the result side free, the input is never held off.
    `SFMF_ASSERT_SAME(a_ready_when_free, !result_valid, text_ready)

endmodule

bind substring_first_match_finder_core sfmf_checker u_sfmf_checker (.*);
